FILE: src/column_box_average_scaler_macros.svh
// Assertion macros shared by the checker files.
`ifndef COLUMN_BOX_AVERAGE_SCALER_MACROS_SVH
`define COLUMN_BOX_AVERAGE_SCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cbas_pkg.sv
package cbas_pkg;

  localparam int PIX_W  = 24;
  localparam int XY_W   = 12;
  localparam int CFG_DW = 25;
  localparam int CFG_IW = 3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_COL_STEP,
    CFG_VIEW_OFFSET,
    CFG_TOP_ROW,
    CFG_ROW_STEP,
    CFG_OUT_WIDTH,
    CFG_OUT_HEIGHT
  } cbas_cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cbas_pix_t;

  typedef struct packed {
    logic [9:0]  src_width;
    logic [8:0]  src_height;
    logic [24:0] col_step;
    logic [19:0] view_offset;
    logic [24:0] top_row;
    logic [23:0] row_step;
    logic [12:0] out_width;
    logic [12:0] out_height;
  } cbas_cfg_t;

  typedef struct packed {
    logic            action;
    logic [7:0]      src_row;
    logic [8:0]      src_col;
    logic [7:0]      red_in;
    logic [7:0]      green_in;
    logic [7:0]      blue_in;
    logic [XY_W-1:0] out_x;
    logic [XY_W-1:0] out_y;
  } cbas_in_t;

  typedef struct packed {
    logic [7:0]      out_red;
    logic [7:0]      out_green;
    logic [7:0]      out_blue;
    logic [XY_W-1:0] pixel_x;
    logic [XY_W-1:0] pixel_y;
  } cbas_out_t;

endpackage

FILE: src/cbas_ram.sv
module cbas_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cbas_fifo.sv
module cbas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/cbas_front.sv
module cbas_front import cbas_pkg::*; #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 256,
  localparam int ADDR_W = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1,
  localparam int CNT_W  = $clog2(MAX_ROWS + 1),
  localparam int CMD_W  = 1 + ADDR_W + PIX_W + CNT_W + 2 * XY_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbas_cfg_t        cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cbas_in_t         in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_full_i,
  output logic [CMD_W-1:0] cmd_o
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    cbas_pix_t         pix;
    logic [CNT_W-1:0]  cnt;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [ADDR_W-1:0] waddr;
    cbas_pix_t         pix;
    logic [45:0]       cprod;
    logic [35:0]       rprod_a;
    logic [36:0]       rprod_b;
  } s1_t;

  typedef struct packed {
    logic              kind;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [ADDR_W-1:0] waddr;
    cbas_pix_t         pix;
    logic [COL_W-1:0]  col;
    logic [37:0]       a;
    logic [37:0]       bp;
  } s2_t;

  logic  v1_q, v2_q, v3_q;
  logic  en1, en2, en3;
  s1_t   s1_q, s1_d;
  s2_t   s2_q, s2_d;
  cmd_t  cmd_q, cmd_d;
  logic  accept, in_store, in_view, keep;
  logic [20:0] vx;
  logic [12:0] y_next;
  logic [12:0] w_sat, h_sat, wm1, hm1;
  logic [29:0] col_full;
  logic [21:0] y0f, y1f;
  logic [12:0] y0c, lo, y1c;
  logic [20:0] y1t;
  logic [ADDR_W-1:0] base;

  // Handshake ripples back through the three stages and the queue.
  assign en3        = !v3_q || !cmd_full_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  assign cmd_valid_o = v3_q;
  assign cmd_o       = cmd_q;

  // Source size used as if saturated into the store's range.
  always_comb begin
    if (cfg_i.src_width == '0) begin
      w_sat = 13'd1;
    end else if (13'(cfg_i.src_width) > 13'(MAX_COLS)) begin
      w_sat = 13'(MAX_COLS);
    end else begin
      w_sat = 13'(cfg_i.src_width);
    end
    if (cfg_i.src_height == '0) begin
      h_sat = 13'd1;
    end else if (13'(cfg_i.src_height) > 13'(MAX_ROWS)) begin
      h_sat = 13'(MAX_ROWS);
    end else begin
      h_sat = 13'(cfg_i.src_height);
    end
  end

  assign wm1 = w_sat - 13'd1;
  assign hm1 = h_sat - 13'd1;

  // Stage 1: classify the word and start the column and row multiplications.
  assign in_store = (32'(in_data_i.src_row) < MAX_ROWS) && (32'(in_data_i.src_col) < MAX_COLS);
  assign in_view  = ({1'b0, in_data_i.out_x} < cfg_i.out_width) &&
                    ({1'b0, in_data_i.out_y} < cfg_i.out_height);
  assign keep     = (in_data_i.action == ACT_WRITE) ? in_store : in_view;
  assign vx       = 21'(cfg_i.view_offset) + 21'(in_data_i.out_x);
  assign y_next   = 13'(in_data_i.out_y) + 13'd1;

  always_comb begin
    s1_d.kind    = in_data_i.action;
    s1_d.x       = in_data_i.out_x;
    s1_d.y       = in_data_i.out_y;
    s1_d.waddr   = ADDR_W'(in_data_i.src_row) * ADDR_W'(MAX_COLS) +
                   ADDR_W'(in_data_i.src_col);
    s1_d.pix     = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    s1_d.cprod   = 46'(vx) * 46'(cfg_i.col_step);
    s1_d.rprod_a = 36'(in_data_i.out_y) * 36'(cfg_i.row_step);
    s1_d.rprod_b = 37'(y_next) * 37'(cfg_i.row_step);
  end

  // Stage 2: column clamp and the two fixed point row bounds.
  assign col_full = s1_q.cprod[45:16];

  always_comb begin
    s2_d.kind  = s1_q.kind;
    s2_d.x     = s1_q.x;
    s2_d.y     = s1_q.y;
    s2_d.waddr = s1_q.waddr;
    s2_d.pix   = s1_q.pix;
    if (col_full > 30'(wm1)) begin
      s2_d.col = COL_W'(wm1);
    end else begin
      s2_d.col = COL_W'(col_full);
    end
    s2_d.a  = 38'($signed(cfg_i.top_row)) + 38'(s1_q.rprod_a);
    // Adding just under one before the floor gives the ceiling of the end bound.
    s2_d.bp = 38'($signed(cfg_i.top_row)) + 38'(s1_q.rprod_b) + 38'd65535;
  end

  // Stage 3: integer rows, clamping, row count and the first address.
  assign y0f = s2_q.a[37:16];
  assign y1f = s2_q.bp[37:16];

  always_comb begin
    if (y0f[21]) begin
      y0c = '0;
    end else if (y0f[20:0] > 21'(hm1)) begin
      y0c = hm1;
    end else begin
      y0c = y0f[12:0];
    end
    lo = y0c + 13'd1;
    if (y1f[21] || (y1f[20:0] < 21'(lo))) begin
      y1t = 21'(lo);
    end else begin
      y1t = y1f[20:0];
    end
    if (y1t > 21'(h_sat)) begin
      y1c = h_sat;
    end else begin
      y1c = y1t[12:0];
    end
  end

  assign base = ADDR_W'(y0c) * ADDR_W'(MAX_COLS) + ADDR_W'(s2_q.col);

  always_comb begin
    cmd_d.kind = s2_q.kind;
    cmd_d.addr = (s2_q.kind == ACT_WRITE) ? s2_q.waddr : base;
    cmd_d.pix  = s2_q.pix;
    cmd_d.cnt  = CNT_W'(y1c - y0c);
    cmd_d.x    = s2_q.x;
    cmd_d.y    = s2_q.y;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept && keep;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

endmodule

FILE: src/cbas_back.sv
module cbas_back import cbas_pkg::*; #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 256,
  localparam int ADDR_W = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1,
  localparam int CNT_W  = $clog2(MAX_ROWS + 1),
  localparam int CMD_W  = 1 + ADDR_W + PIX_W + CNT_W + 2 * XY_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cbas_out_t        out_data_o
);

  localparam int SUM_W = CNT_W + 8;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    cbas_pix_t         pix;
    logic [CNT_W-1:0]  cnt;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV
  } state_e;

  state_e            state_q;
  cmd_t              cmd;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  rem_q, cnt_q;
  logic              acc_q;
  logic [SUM_W-1:0]  sum_q [3];
  logic [SUM_W-1:0]  sum_div [3];
  logic [7:0]        quo_q [3];
  logic [7:0]        quo_div [3];
  logic [7:0]        rd_ch [3];
  logic [2:0]        ge;
  logic [SUM_W-1:0]  dvs_q;
  logic [2:0]        step_q;
  logic [XY_W-1:0]   x_q, y_q;
  logic              out_valid_q;
  cbas_out_t         out_q;
  logic              ram_we, ram_re, out_free, out_load;
  logic [PIX_W-1:0]  ram_rdata;
  cbas_pix_t         rd_pix;

  assign cmd       = cmd_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_we    = cmd_pop_o && (cmd.kind == ACT_WRITE);
  assign ram_re    = (state_q == ST_READ);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == ST_DIV) && (step_q == '0) && out_free;

  cbas_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_COLS * MAX_ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd.addr),
    .wdata_i (cmd.pix),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_pix   = ram_rdata;
  assign rd_ch[0] = rd_pix.red;
  assign rd_ch[1] = rd_pix.green;
  assign rd_ch[2] = rd_pix.blue;

  // One restoring division step per cycle for all three channels, the last held while
  // the output is stalled. The average never exceeds 255: eight quotient bits cover it.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ge[c]      = (sum_q[c] >= dvs_q);
      sum_div[c] = ge[c] ? (sum_q[c] - dvs_q) : sum_q[c];
      quo_div[c] = {quo_q[c][6:0], ge[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Read data arrives in the cycle after its address.
      if (acc_q) begin
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= sum_q[c] + SUM_W'(rd_ch[c]);
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && (cmd.kind == ACT_RENDER)) begin
            for (int c = 0; c < 3; c++) begin
              sum_q[c] <= '0;
            end
            addr_q  <= cmd.addr;
            rem_q   <= cmd.cnt;
            cnt_q   <= cmd.cnt;
            x_q     <= cmd.x;
            y_q     <= cmd.y;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          addr_q <= addr_q + ADDR_W'(MAX_COLS);
          rem_q  <= rem_q - 1'b1;
          acc_q  <= 1'b1;
          if (rem_q == CNT_W'(1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          acc_q   <= 1'b0;
          dvs_q   <= SUM_W'(cnt_q) << 7;
          step_q  <= 3'd7;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if ((step_q != '0) || out_free) begin
            for (int c = 0; c < 3; c++) begin
              sum_q[c] <= sum_div[c];
              quo_q[c] <= quo_div[c];
            end
            dvs_q  <= dvs_q >> 1;
            step_q <= step_q - 1'b1;
          end
          if (out_load) begin
            out_q.out_red   <= quo_div[0];
            out_q.out_green <= quo_div[1];
            out_q.out_blue  <= quo_div[2];
            out_q.pixel_x   <= x_q;
            out_q.pixel_y   <= y_q;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/column_box_average_scaler.sv
// Column box average scaler. Write words (action 0) store one RGB pixel at (src_row, src_col);
// render words (action 1) return the average of one source column over the rows that output
// row out_y covers, with the column and row range worked out in 16.16 fixed point from the
// configuration registers; a render word outside out_width by out_height returns nothing. A
// three-stage front end does the address arithmetic and feeds a four-entry command queue, so
// input words keep being taken while the back end is busy or its result waits, until the
// queue fills. The back end retires a write word as it pops it; a render word takes the
// command, reads one pixel per cycle for each of the N rows averaged (1 to MAX_ROWS) from
// the single read port of the image store, lets the last read land, then runs a shared
// bit-per-cycle divider whose last step waits while its output is stalled. The store is
// not cleared at reset: reading a pixel that was never written gives an undefined value.
module column_box_average_scaler import cbas_pkg::*; #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbas_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbas_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int ADDR_W = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CMD_W  = 1 + ADDR_W + PIX_W + CNT_W + 2 * XY_W;

  cbas_cfg_t        cfg_q;
  logic             q_push, q_full, q_pop, q_empty;
  logic [CMD_W-1:0] q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width   <= 10'd512;
      cfg_q.src_height  <= 9'd256;
      cfg_q.col_step    <= 25'd65536;
      cfg_q.view_offset <= '0;
      cfg_q.top_row     <= '0;
      cfg_q.row_step    <= 24'd65536;
      cfg_q.out_width   <= 13'd512;
      cfg_q.out_height  <= 13'd256;
    end else if (cfg_we_i) begin
      case (cbas_cfg_idx_e'(cfg_idx_i))
        CFG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data_i[9:0];
        CFG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data_i[8:0];
        CFG_COL_STEP:    cfg_q.col_step    <= cfg_data_i[24:0];
        CFG_VIEW_OFFSET: cfg_q.view_offset <= cfg_data_i[19:0];
        CFG_TOP_ROW:     cfg_q.top_row     <= cfg_data_i[24:0];
        CFG_ROW_STEP:    cfg_q.row_step    <= cfg_data_i[23:0];
        CFG_OUT_WIDTH:   cfg_q.out_width   <= cfg_data_i[12:0];
        CFG_OUT_HEIGHT:  cfg_q.out_height  <= cfg_data_i[12:0];
        default: begin
        end
      endcase
    end
  end

  cbas_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (q_push),
    .cmd_full_i  (q_full),
    .cmd_o       (q_in)
  );

  cbas_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  cbas_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/cbas_checker.sv
`include "column_box_average_scaler_macros.svh"

module cbas_checker import cbas_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input cbas_in_t          in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cbas_out_t         out_data_o,
  input logic              cfg_we_i,
  input logic [CFG_IW-1:0] cfg_idx_i,
  input logic [CFG_DW-1:0] cfg_data_i
);

  logic [12:0] ow_q, oh_q;
  logic [4:0]  pend_q;
  logic        owed_in, paid_out;

  // Shadow copy of the visible output size, taken from the register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q <= 13'd512;
      oh_q <= 13'd256;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_OUT_WIDTH) begin
        ow_q <= cfg_data_i[12:0];
      end
      if (cfg_idx_i == CFG_OUT_HEIGHT) begin
        oh_q <= cfg_data_i[12:0];
      end
    end
  end

  assign owed_in  = in_valid_i && !in_stall_o && (in_data_i.action == ACT_RENDER) &&
                    ({1'b0, in_data_i.out_x} < ow_q) && ({1'b0, in_data_i.out_y} < oh_q);
  assign paid_out = out_valid_o && !out_stall_i;

  // Render words accepted inside the view whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 5'(owed_in) - 5'(paid_out);
    end
  end

  `CBAS_ASSERT_NXT(ast_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result word changed or vanished")

  `CBAS_ASSERT_IMP(ast_out_in_view, clk_i, rst_ni, out_valid_o, ({1'b0, out_data_o.pixel_x} < ow_q) && ({1'b0, out_data_o.pixel_y} < oh_q), "result word lies outside the visible output")

  `CBAS_ASSERT_IMP(ast_out_owed, clk_i, rst_ni, out_valid_o, pend_q != 5'd0, "result word without an outstanding render word")

endmodule

bind column_box_average_scaler cbas_checker u_checker (.*);
